FILE: hw/rtl/mpfb_pkg.sv
// Shared constants, types and the digit font for the page framebuffer engine.
// Depends on nothing; every other RTL file uses it.
`default_nettype none

package mpfb_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 84;
    localparam int SCREEN_HEIGHT = 48;
    localparam int PAGE_COUNT    = 6;
    localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_SIZE);
    localparam int PAGE_W        = 5;
    localparam int SUM_W         = 13;

    // Command fields
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_PIXEL = 3'd1;
    localparam logic [OP_W-1:0] OP_RECT  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIGIT = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [2:0] GLYPH_LAST_COL = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RECT_TEST,
        ST_RECT_WRITE,
        ST_GLYPH,
        ST_RD_ISSUE,
        ST_RD_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

    function automatic logic [7:0] font_byte(input logic [3:0] digit, input logic [2:0] col);
        logic [39:0] row;
        case (digit)
            4'd0:    row = 40'h3E_51_49_45_3E;
            4'd1:    row = 40'h00_42_7F_40_00;
            4'd2:    row = 40'h42_61_51_49_46;
            4'd3:    row = 40'h21_41_45_4B_31;
            4'd4:    row = 40'h18_14_12_7F_10;
            4'd5:    row = 40'h27_45_45_45_39;
            4'd6:    row = 40'h3C_4A_49_49_30;
            4'd7:    row = 40'h01_71_09_05_03;
            4'd8:    row = 40'h36_49_49_49_36;
            4'd9:    row = 40'h06_49_49_29_1E;
            default: row = 40'h0;
        endcase
        case (col)
            3'd0:    font_byte = row[39:32];
            3'd1:    font_byte = row[31:24];
            3'd2:    font_byte = row[23:16];
            3'd3:    font_byte = row[15:8];
            3'd4:    font_byte = row[7:0];
            default: font_byte = 8'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mpfb_if.sv
// Valid/ready channel interfaces: drawing commands in, framebuffer bytes out.
// Depends on mpfb_pkg for field widths.
`default_nettype none

interface mpfb_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [mpfb_pkg::OP_W-1:0]      op;
    logic [7:0]                     x_pos;
    logic [7:0]                     y_pos;
    logic [7:0]                     rect_width;
    logic [7:0]                     rect_height;
    logic                           pixel_on;
    logic [7:0]                     page_row;
    logic [7:0]                     char_code;

    modport source (output valid, op, x_pos, y_pos, rect_width, rect_height,
                    pixel_on, page_row, char_code, input ready);
    modport sink   (input valid, op, x_pos, y_pos, rect_width, rect_height,
                    pixel_on, page_row, char_code, output ready);
endinterface

interface mpfb_rd_if;
    logic                           valid;
    logic                           ready;
    logic [mpfb_pkg::BYTE_W-1:0]    pixel_byte;
    logic                           frame_end;

    modport source (output valid, pixel_byte, frame_end, input ready);
    modport sink   (input valid, pixel_byte, frame_end, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mpfb_store.sv
// Frame store: one write port and one read port with registered read data.
// Depends on mpfb_pkg for the request struct and store size.
`default_nettype none

module mpfb_store (
    input  wire logic                   i_clk,
    input  wire mpfb_pkg::t_store_req   i_req,
    output logic [7:0]                  o_rd_data
);
    import mpfb_pkg::*;

    logic [7:0] r_mem [STORE_SIZE];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hw/rtl/mono_page_framebuffer_engine.sv
// Top level of the page framebuffer engine: command sequencer, shared address
// unit and output register. Depends on mpfb_pkg, mpfb_if and mpfb_store.
`default_nettype none

//  channel   modport          payload                                   transfer
//  i_cmd     mpfb_cmd_if.sink op x_pos y_pos rect_width rect_height      valid && ready
//                             pixel_on page_row char_code
//  o_rd      mpfb_rd_if.source pixel_byte frame_end                      valid && ready
//
//  Per command: clear writes one store byte per cycle across the whole store;
//  pixel is a one by one rectangle; a rectangle tests each pixel in turn and
//  reads then writes back each visible one through the one store port; digit
//  writes one glyph column per cycle; read fetches a byte, then outputs it.
//  After reset the store is swept to zero while i_cmd.ready is low.
//  The output register holds a byte until it is taken; a read command waits in
//  its last step while that register is full, other commands proceed.

module mono_page_framebuffer_engine (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mpfb_cmd_if.sink        i_cmd,
    mpfb_rd_if.source       o_rd
);
    import mpfb_pkg::*;

    t_state r_state, n_state;

    // Command operands
    logic [7:0]        r_x, n_x;
    logic [7:0]        r_y, n_y;
    logic [7:0]        r_w, n_w;
    logic [7:0]        r_h, n_h;
    logic              r_on, n_on;
    logic [7:0]        r_page, n_page;
    logic [3:0]        r_digit, n_digit;

    // Iteration counters
    logic [7:0]        r_dx, n_dx;
    logic [7:0]        r_dy, n_dy;
    logic [2:0]        r_col, n_col;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [2:0]        r_bit, n_bit;
    logic [ADDR_W-1:0] r_rd_ptr, n_rd_ptr;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic              r_out_end, n_out_end;

    // Shared address unit: page * SCREEN_WIDTH + column
    logic [PAGE_W-1:0] au_page;
    logic [7:0]        au_col;
    logic [SUM_W-1:0]  au_sum;
    logic [ADDR_W-1:0] au_addr;

    logic [7:0]        px_x, px_y;
    logic              px_vis;
    logic [8:0]        gl_x;
    logic              gl_vis;
    logic              rect_last_dx, rect_last_dy;
    logic              slot_free;
    logic              cmd_ok_digit;
    logic [7:0]        bit_mask;
    logic [7:0]        rd_data;
    t_store_req        store_req;

    mpfb_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    // Rectangle pixel coordinates wrap in eight bits before clipping
    assign px_x   = r_x + r_dx;
    assign px_y   = r_y + r_dy;
    assign px_vis = (px_x < 8'(SCREEN_WIDTH)) && (px_y < 8'(SCREEN_HEIGHT))
                    && (px_y[7:3] < PAGE_W'(PAGE_COUNT));

    // Glyph columns do not wrap
    assign gl_x   = {1'b0, r_x} + 9'(r_col);
    assign gl_vis = gl_x < 9'(SCREEN_WIDTH);

    assign rect_last_dx = (r_dx == r_w - 8'd1);
    assign rect_last_dy = (r_dy == r_h - 8'd1);

    always_comb begin
        if (r_state == ST_GLYPH) begin
            au_page = r_page[PAGE_W-1:0];
            au_col  = gl_x[7:0];
        end else begin
            au_page = px_y[7:3];
            au_col  = px_x;
        end
        au_sum  = SUM_W'(au_page) * SUM_W'(SCREEN_WIDTH) + SUM_W'(au_col);
        au_addr = au_sum[ADDR_W-1:0];
    end

    assign slot_free    = !r_out_valid || o_rd.ready;
    assign cmd_ok_digit = (i_cmd.char_code >= CHAR_ZERO) && (i_cmd.char_code <= CHAR_NINE)
                          && (i_cmd.page_row < 8'(PAGE_COUNT));
    assign bit_mask     = 8'd1 << r_bit;

    assign i_cmd.ready     = (r_state == ST_IDLE);
    assign o_rd.valid      = r_out_valid;
    assign o_rd.pixel_byte = r_out_byte;
    assign o_rd.frame_end  = r_out_end;

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_h         = r_h;
        n_on        = r_on;
        n_page      = r_page;
        n_digit     = r_digit;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_col       = r_col;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_bit       = r_bit;
        n_rd_ptr    = r_rd_ptr;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;

        store_req       = '0;
        store_req.waddr = r_addr;
        store_req.raddr = au_addr;

        // Drop the held byte once it is taken
        if (r_out_valid && o_rd.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_x     = i_cmd.x_pos;
                    n_y     = i_cmd.y_pos;
                    n_w     = i_cmd.rect_width;
                    n_h     = i_cmd.rect_height;
                    n_on    = i_cmd.pixel_on;
                    n_page  = i_cmd.page_row;
                    n_digit = 4'(i_cmd.char_code - CHAR_ZERO);
                    n_dx    = 8'd0;
                    n_dy    = 8'd0;
                    n_col   = 3'd0;
                    n_clr   = '0;
                    case (i_cmd.op)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_PIXEL: begin
                            // A pixel is a one by one rectangle
                            n_w     = 8'd1;
                            n_h     = 8'd1;
                            n_state = ST_RECT_TEST;
                        end
                        OP_RECT: begin
                            if (i_cmd.rect_width != 8'd0 && i_cmd.rect_height != 8'd0) begin
                                n_state = ST_RECT_TEST;
                            end
                        end
                        OP_DIGIT: begin
                            if (cmd_ok_digit) begin
                                n_state = ST_GLYPH;
                            end
                        end
                        OP_READ:  n_state = ST_RD_ISSUE;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end

            ST_CLEAR: begin
                store_req.we    = 1'b1;
                store_req.waddr = r_clr;
                store_req.wdata = 8'h00;
                n_clr           = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(STORE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_RECT_TEST: begin
                if (px_vis) begin
                    // Fetch the byte, modify it next cycle
                    store_req.re = 1'b1;
                    n_addr       = au_addr;
                    n_bit        = px_y[2:0];
                    n_state      = ST_RECT_WRITE;
                end else if (rect_last_dx) begin
                    n_dx = 8'd0;
                    n_dy = r_dy + 8'd1;
                    if (rect_last_dy) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_dx = r_dx + 8'd1;
                end
            end

            ST_RECT_WRITE: begin
                store_req.we    = 1'b1;
                store_req.wdata = r_on ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
                n_state         = ST_RECT_TEST;
                if (rect_last_dx) begin
                    n_dx = 8'd0;
                    n_dy = r_dy + 8'd1;
                    if (rect_last_dy) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_dx = r_dx + 8'd1;
                end
            end

            ST_GLYPH: begin
                // Glyph columns overwrite whole bytes
                store_req.we    = gl_vis;
                store_req.waddr = au_addr;
                store_req.wdata = font_byte(r_digit, r_col);
                n_col           = r_col + 3'd1;
                if (r_col == GLYPH_LAST_COL) begin
                    n_state = ST_IDLE;
                end
            end

            ST_RD_ISSUE: begin
                store_req.re    = 1'b1;
                store_req.raddr = r_rd_ptr;
                n_state         = ST_RD_DONE;
            end

            ST_RD_DONE: begin
                // Hold the fetched byte until the output register frees up
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = rd_data;
                    n_out_end   = (r_rd_ptr == ADDR_W'(STORE_SIZE - 1));
                    n_rd_ptr    = n_out_end ? '0 : r_rd_ptr + ADDR_W'(1);
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Control state; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_dx        <= 8'd0;
            r_dy        <= 8'd0;
            r_col       <= 3'd0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_col       <= n_col;
            r_rd_ptr    <= n_rd_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_w        <= n_w;
        r_h        <= n_h;
        r_on       <= n_on;
        r_page     <= n_page;
        r_digit    <= n_digit;
        r_addr     <= n_addr;
        r_bit      <= n_bit;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking bench for the page framebuffer engine: drives drawing commands,
// predicts every read-back byte, and compares. Depends on mpfb_pkg and mpfb_if.
`timescale 1ns / 1ps

module tb;
    import mpfb_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 8;
    localparam int          ITEM_TARGET   = 1950;
    localparam int          SEGMENT_ITEMS = 120;
    localparam int          SETTLE_CYCLES = 1000;
    localparam int          CYCLE_LIMIT   = 1500000;
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

    // Digit glyphs, five columns per digit, column 0 in the top byte.
    localparam logic [0:9][39:0] GLYPH_BITS = {
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46,
        40'h21_41_45_4B_31, 40'h18_14_12_7F_10, 40'h27_45_45_45_39,
        40'h3C_4A_49_49_30, 40'h01_71_09_05_03, 40'h36_49_49_49_36,
        40'h06_49_49_29_1E
    };

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      x_pos;
        logic [7:0]      y_pos;
        logic [7:0]      rect_width;
        logic [7:0]      rect_height;
        logic            pixel_on;
        logic [7:0]      page_row;
        logic [7:0]      char_code;
    } draw_cmd_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       frame_end;
    } sweep_byte_t;

    // Shadow copy of the framebuffer; yields the byte each read must return.
    class page_image_model;
        logic [7:0]  image [STORE_SIZE];
        int          sweep_ptr;
        sweep_byte_t due_bytes [$];
        int          errors;
        int          bytes_checked;
        int          frame_wraps;

        function new();
            foreach (image[i]) image[i] = 8'h00;
            sweep_ptr     = 0;
            errors        = 0;
            bytes_checked = 0;
            frame_wraps   = 0;
        endfunction

        function int outstanding();
            return due_bytes.size();
        endfunction

        function void plot(int x, int y, logic on);
            int idx;
            if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
            idx = (y >> 3) * SCREEN_WIDTH + x;
            if (idx >= STORE_SIZE) return;
            image[idx][y & 7] = on;
        endfunction

        function void apply_cmd(draw_cmd_t c);
            sweep_byte_t b;
            int          idx;
            logic [7:0]  xs;
            logic [7:0]  ys;
            case (c.op)
                OP_CLEAR: begin
                    foreach (image[i]) image[i] = 8'h00;
                end
                OP_PIXEL: plot(int'(c.x_pos), int'(c.y_pos), c.pixel_on);
                OP_RECT: begin
                    for (int dy = 0; dy < c.rect_height; dy++) begin
                        for (int dx = 0; dx < c.rect_width; dx++) begin
                            // corner offsets wrap at 8 bits before clipping
                            xs = c.x_pos + dx[7:0];
                            ys = c.y_pos + dy[7:0];
                            plot(int'(xs), int'(ys), c.pixel_on);
                        end
                    end
                end
                OP_DIGIT: begin
                    if (c.char_code >= CHAR_ZERO && c.char_code <= CHAR_NINE &&
                            c.page_row < PAGE_COUNT) begin
                        for (int col = 0; col < 5; col++) begin
                            if (int'(c.x_pos) + col < SCREEN_WIDTH) begin
                                idx = c.page_row * SCREEN_WIDTH + c.x_pos + col;
                                if (idx < STORE_SIZE)
                                    image[idx] = GLYPH_BITS[c.char_code - CHAR_ZERO]
                                                           [39 - 8 * col -: 8];
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (sweep_ptr >= STORE_SIZE) sweep_ptr = 0;
                    b.pixel_byte = image[sweep_ptr];
                    b.frame_end  = (sweep_ptr + 1 == STORE_SIZE);
                    due_bytes.push_back(b);
                    sweep_ptr = b.frame_end ? 0 : sweep_ptr + 1;
                end
                default: ;
            endcase
        endfunction

        function void check_read(logic [7:0] pixel_byte, logic frame_end);
            sweep_byte_t exp_b;
            if (due_bytes.size() == 0) begin
                $display("%0t: unexpected read byte %02h frame_end %0b",
                         $time, pixel_byte, frame_end);
                errors++;
                return;
            end
            exp_b = due_bytes.pop_front();
            bytes_checked++;
            if (frame_end) frame_wraps++;
            if (pixel_byte !== exp_b.pixel_byte) begin
                $display("%0t: pixel_byte mismatch, expected %02h got %02h",
                         $time, exp_b.pixel_byte, pixel_byte);
                errors++;
            end
            if (frame_end !== exp_b.frame_end) begin
                $display("%0t: frame_end mismatch, expected %0b got %0b",
                         $time, exp_b.frame_end, frame_end);
                errors++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mpfb_cmd_if cmd_ch ();
    mpfb_rd_if  rd_ch ();

    mono_page_framebuffer_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rd    (rd_ch)
    );

    page_image_model model = new();

    // Idle enables; the random part switches them per segment so that some
    // stretches run back to back on one or both sides.
    logic tx_idle_en = 1'b1;
    logic rd_idle_en = 1'b1;
    int   op_seen [8];
    int   cycle_count = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: a correct run finishes far below this.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d bytes still due",
                     $time, cycle_count, model.outstanding());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic draw_cmd_t cmd_of(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                         logic [7:0] w, logic [7:0] h, logic on,
                                         logic [7:0] page, logic [7:0] code);
        draw_cmd_t c;
        c.op = op;         c.x_pos = x;        c.y_pos = y;
        c.rect_width = w;  c.rect_height = h;  c.pixel_on = on;
        c.page_row = page; c.char_code = code;
        return c;
    endfunction

    // Present one command after a random gap; hold it until the transfer.
    task automatic send_cmd(input draw_cmd_t c);
        int unsigned gap;
        gap = tx_idle_en ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.op          <= c.op;
        cmd_ch.x_pos       <= c.x_pos;
        cmd_ch.y_pos       <= c.y_pos;
        cmd_ch.rect_width  <= c.rect_width;
        cmd_ch.rect_height <= c.rect_height;
        cmd_ch.pixel_on    <= c.pixel_on;
        cmd_ch.page_row    <= c.page_row;
        cmd_ch.char_code   <= c.char_code;
        do @(posedge i_clk); while (!cmd_ch.ready);
        model.apply_cmd(c);
        op_seen[c.op]++;
    endtask

    // Drop valid and hold off until every pending read byte has come back.
    task automatic wait_reads_drained();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (model.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] near_range(int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'($urandom_range(0, span + 3));
        if (r < 85) return 8'($urandom_range(240, 255));
        return 8'($urandom);
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t   c;
        int unsigned r;
        // Fill every field so unused ones toggle too, then shape per operation.
        c.x_pos = 8'($urandom);       c.y_pos = 8'($urandom);
        c.rect_width = 8'($urandom);  c.rect_height = 8'($urandom);
        c.pixel_on = 1'($urandom);    c.page_row = 8'($urandom);
        c.char_code = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 3) begin
            c.op = OP_CLEAR;
        end else if (r < 18) begin
            c.op    = OP_PIXEL;
            c.x_pos = near_range(SCREEN_WIDTH);
            c.y_pos = near_range(SCREEN_HEIGHT);
        end else if (r < 33) begin
            c.op    = OP_RECT;
            c.x_pos = near_range(SCREEN_WIDTH);
            c.y_pos = near_range(SCREEN_HEIGHT);
            // keep most rectangles small; one long side now and then
            case ($urandom_range(0, 19))
                0: begin
                    c.rect_height = 8'($urandom_range(0, 3));
                end
                1: begin
                    c.rect_width = 8'($urandom_range(0, 3));
                end
                default: begin
                    c.rect_width  = 8'($urandom_range(0, 15));
                    c.rect_height = 8'($urandom_range(0, 15));
                end
            endcase
        end else if (r < 46) begin
            c.op = OP_DIGIT;
            if ($urandom_range(0, 3) != 0) begin
                c.x_pos    = 8'($urandom_range(0, SCREEN_WIDTH));
                c.page_row = 8'($urandom_range(0, PAGE_COUNT));
                c.char_code = 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
            end
        end else if (r < 95) begin
            c.op = OP_READ;
        end else begin
            c.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return c;
    endfunction

    // Read-back side: random stall before each byte, then take it and check.
    initial begin : rd_drain
        int unsigned stall;
        @(posedge i_rst_n);
        forever begin
            stall = rd_idle_en ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
                @(negedge i_clk);
                rd_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rd_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rd_ch.valid);
            model.check_read(rd_ch.pixel_byte, rd_ch.frame_end);
        end
    end

    initial begin : stimulus
        draw_cmd_t c;
        int        counted;
        int        seg_left;

        cmd_ch.valid       = 1'b0;
        cmd_ch.op          = OP_CLEAR;
        cmd_ch.x_pos       = '0;
        cmd_ch.y_pos       = '0;
        cmd_ch.rect_width  = '0;
        cmd_ch.rect_height = '0;
        cmd_ch.pixel_on    = 1'b0;
        cmd_ch.page_row    = '0;
        cmd_ch.char_code   = '0;
        rd_ch.ready        = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: freshly cleared store, clipping edges, wrapping rectangle,
        // glyph clipping and rejected codes, clear, unused opcodes.
        send_cmd(cmd_of(OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_PIXEL, 8'd83,  8'd47,  8'd0,   8'd0,   1'b1, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_PIXEL, 8'd84,  8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_PIXEL, 8'd0,   8'd48,  8'd0,   8'd0,   1'b1, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_PIXEL, 8'd255, 8'd255, 8'd0,   8'd0,   1'b1, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_RECT,  8'd0,   8'd0,   8'd0,   8'd5,   1'b1, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_RECT,  8'd0,   8'd0,   8'd5,   8'd0,   1'b1, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_RECT,  8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_RECT,  8'd250, 8'd250, 8'd20,  8'd20,  1'b0, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_RECT,  8'd80,  8'd44,  8'd10,  8'd10,  1'b0, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_PIXEL, 8'd2,   8'd1,   8'd0,   8'd0,   1'b0, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_DIGIT, 8'd2,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, CHAR_ZERO));
        send_cmd(cmd_of(OP_DIGIT, 8'd80,  8'd0,   8'd0,   8'd0,   1'b0, 8'd5, CHAR_NINE));
        send_cmd(cmd_of(OP_DIGIT, 8'd10,  8'd0,   8'd0,   8'd0,   1'b0, 8'd6, CHAR_ZERO));
        send_cmd(cmd_of(OP_DIGIT, 8'd10,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'h2F));
        send_cmd(cmd_of(OP_DIGIT, 8'd10,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'h3A));
        send_cmd(cmd_of(OP_DIGIT, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd255, 8'hFF));
        send_cmd(cmd_of(OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_SPARE_FIRST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF));
        send_cmd(cmd_of(OP_SPARE_LAST,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00));
        send_cmd(cmd_of(OP_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'h00));
        send_cmd(cmd_of(OP_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'h00));

        // Let the output side empty completely before the random part.
        wait_reads_drained();

        counted  = 0;
        seg_left = 0;
        while (counted < ITEM_TARGET) begin
            if (seg_left == 0) begin
                seg_left = SEGMENT_ITEMS;
                case ($urandom_range(0, 3))
                    0: begin tx_idle_en = 1'b1; rd_idle_en = 1'b1; end
                    1: begin tx_idle_en = 1'b0; rd_idle_en = 1'b1; end
                    2: begin tx_idle_en = 1'b1; rd_idle_en = 1'b0; end
                    default: begin tx_idle_en = 1'b0; rd_idle_en = 1'b0; end
                endcase
                if ($urandom_range(0, 1) != 0) wait_reads_drained();
            end
            c = random_cmd();
            send_cmd(c);
            seg_left--;
            // unused opcodes only exercise the decoder; don't count them
            if (c.op < OP_SPARE_FIRST) counted++;
        end

        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (model.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered: clear %0d, pixel %0d, rect %0d, digit %0d, read %0d, unused %0d",
                 op_seen[OP_CLEAR], op_seen[OP_PIXEL], op_seen[OP_RECT],
                 op_seen[OP_DIGIT], op_seen[OP_READ],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        $display("read-back: %0d bytes compared over %0d full frame sweeps, %0d errors",
                 model.bytes_checked, model.frame_wraps, model.errors);
        if (model.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
